// ----- sv/dq_pkg.sv -----
// Package for the double-ended queue: sizes, request codes, payload structs
// and the controller/datapath interface types. Depends on nothing.
package dq_pkg;

    // Queue depth and derived index and count widths.
    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int DATA_W  = 32;
    localparam int REQ_W   = 3;
    localparam int COUNT_W = 5;

    // Request codes carried in req_type.
    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_CLEAR      = 3'd4,
        REQ_PEEK       = 3'd5
    } req_code_t;

    // Input item.
    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic signed [DATA_W-1:0] value;
    } dq_req_t;

    // Result item.
    typedef struct packed {
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
        logic [COUNT_W-1:0]       count;
        logic                     is_empty;
        logic                     is_full;
        logic                     refused;
    } dq_rsp_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;
        logic load;
    } dq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } dq_status_t;

    // Reduce a sum below twice the depth into a ring index.
    function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] depth_s;
        depth_s = SUM_W'(DEPTH);
        if (s >= depth_s) begin
            return IDX_W'(s - depth_s);
        end
        return IDX_W'(s);
    endfunction

endpackage

// ----- sv/double_ended_queue_top.sv -----
// Top level of the bounded double-ended queue of signed 32-bit values.
// A request is taken in idle; the queue state and the ring store are updated,
// the store's registered read follows that write, and the result is loaded once
// the output register is free. No new request is taken until the result is loaded.
// Reset: aresetn (synchronous, active low) empties the queue; the store
// itself is not cleared. Depends on dq_pkg, dq_ctrl, dq_dpath and dq_ram.
module double_ended_queue_top (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  dq_pkg::dq_req_t s_req,
    output logic            m_valid,
    input  logic            m_ready,
    output dq_pkg::dq_rsp_t m_rsp
);
    import dq_pkg::*;

    dq_cmd_t    cmd;
    dq_status_t status;

    // Sequencer.
    dq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Queue storage and result path.
    dq_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_req   (s_req),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    // A request transfer is followed by a valid result.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> ##3 m_valid)
        else $error("result missing three cycles after a request transfer");

    // Only one request is in flight at a time.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready again right after a transfer");

    // An empty result reads zero at both ends and a zero count.
    a_empty_reads_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rsp.is_empty |->
            m_rsp.front_value == '0 && m_rsp.back_value == '0 && m_rsp.count == '0)
        else $error("empty result with nonzero fields");

    // Full and empty flags never appear together.
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_rsp.is_full && m_rsp.is_empty))
        else $error("result both full and empty");

endmodule

// ----- sv/dq_ram.sv -----
// Generic RAM with one write port and two registered read ports.
// Depends on nothing.
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read ports.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- sv/dq_ctrl.sv -----
// Controller for the double-ended queue: sequences accept, read and load.
// Depends on dq_pkg.
module dq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dq_pkg::dq_status_t status,
    output dq_pkg::dq_cmd_t    cmd
);
    import dq_pkg::*;

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        s_ready  = 1'b0;
        cmd.exec = 1'b0;
        cmd.load = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.exec = s_valid;
            end
            ST_READ: begin
            end
            ST_LOAD: begin
                cmd.load = status.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- sv/dq_dpath.sv -----
// Datapath for the double-ended queue: head and count registers, ring store
// and the result register. Depends on dq_pkg and dq_ram.
module dq_dpath (
    input  logic               aclk,
    input  logic               aresetn,
    input  dq_pkg::dq_req_t    s_req,
    input  dq_pkg::dq_cmd_t    cmd,
    output dq_pkg::dq_status_t status,
    output logic               m_valid,
    input  logic               m_ready,
    output dq_pkg::dq_rsp_t    m_rsp
);
    import dq_pkg::*;

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              refused_reg, refused_next;
    logic              m_valid_reg;
    dq_rsp_t           rsp_reg;

    logic              full;
    logic              empty;
    logic [IDX_W-1:0]  tail_slot;
    logic [IDX_W-1:0]  head_dec;
    logic [IDX_W-1:0]  head_inc;
    logic [IDX_W-1:0]  back_addr;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] rd_front;
    logic [DATA_W-1:0] rd_back;

    // Ring index arithmetic.
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign tail_slot = wrap_idx(SUM_W'(head_reg) + SUM_W'(count_reg));
    assign head_dec  = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - IDX_W'(1);
    assign head_inc  = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);
    assign back_addr = empty ? head_reg
                     : wrap_idx(SUM_W'(head_reg) + SUM_W'(count_reg) - SUM_W'(1));

    // Request decode: next head, count, refused flag and store write.
    always_comb begin
        head_next    = head_reg;
        count_next   = count_reg;
        refused_next = 1'b0;
        we           = 1'b0;
        waddr        = tail_slot;
        unique case (s_req.req_type)
            REQ_PUSH_FRONT: begin
                if (full) begin
                    refused_next = 1'b1;
                end else begin
                    head_next  = head_dec;
                    count_next = count_reg + CNT_W'(1);
                    we         = cmd.exec;
                    waddr      = head_dec;
                end
            end
            REQ_PUSH_BACK: begin
                if (full) begin
                    refused_next = 1'b1;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                    we         = cmd.exec;
                end
            end
            REQ_POP_FRONT: begin
                if (empty) begin
                    refused_next = 1'b1;
                end else begin
                    head_next  = head_inc;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            REQ_POP_BACK: begin
                if (empty) begin
                    refused_next = 1'b1;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            REQ_CLEAR: begin
                head_next  = '0;
                count_next = '0;
            end
            default: begin
            end
        endcase
    end

    // Queue state registers, updated when a request is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else if (cmd.exec) begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            refused_reg <= refused_next;
        end
    end

    // Ring store: front and back are read in the cycle after the update.
    dq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (s_req.value),
        .raddr_a (head_reg),
        .rdata_a (rd_front),
        .raddr_b (back_addr),
        .rdata_b (rd_back)
    );

    // Result register and its valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rsp_reg.front_value <= empty ? '0 : rd_front;
            rsp_reg.back_value  <= empty ? '0 : rd_back;
            rsp_reg.count       <= COUNT_W'(count_reg);
            rsp_reg.is_empty    <= empty;
            rsp_reg.is_full     <= full;
            rsp_reg.refused     <= refused_reg;
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_rsp           = rsp_reg;

endmodule
